FILE: rtl/core/pce_pkg.sv
// ----------------------------------------------------------------------------
// pce_pkg
// shared constants and register map of the parameterized crc engine
// ----------------------------------------------------------------------------
package pce_pkg;

  localparam int DEF_MAX_CRC_WIDTH = 32;
  localparam int CFG_AW            = 5;
  localparam int CFG_DW            = 32;
  localparam int IN_DW             = 8;
  localparam int OUT_DW            = 32;
  localparam int WIDTH_FW          = 6;
  localparam int MIN_CRC_WIDTH     = 8;

  localparam logic [WIDTH_FW-1:0] RST_CRC_WIDTH = 6'd32;
  localparam logic [31:0]         RST_POLY      = 32'h04C1_1DB7;
  localparam logic [31:0]         RST_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0]         RST_XOROUT    = 32'h0000_0000;

  typedef enum logic [2:0] {
    REG_CRC_WIDTH      = 3'd0,
    REG_POLYNOMIAL     = 3'd1,
    REG_INITIAL_VALUE  = 3'd2,
    REG_REFLECT_INPUT  = 3'd3,
    REG_REFLECT_OUTPUT = 3'd4,
    REG_FINAL_XOR      = 3'd5
  } reg_idx_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/parameterized_crc_engine.sv
// ----------------------------------------------------------------------------
// parameterized_crc_engine
// configurable-width crc over a byte stream, one crc word per input byte
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle unless the result side stalls and returns,
// for every byte, the crc of the message so far. A byte is captured in an
// input register; as it advances, the eight shift/xor division steps, input
// and output reflection and the final xor run in one pass into the result
// and crc registers. The crc register feedback through that single pass
// sets the rate of one byte per cycle. A byte with restart set loads the
// initial value first. Width is clamped to 8..MAX_CRC_WIDTH; bits of
// crc_value above the width read zero. Registers sit on an apb-style port at
// byte address 4*i and are to be written only while the engine is idle.
// ----------------------------------------------------------------------------
module parameterized_crc_engine
  import pce_pkg::*;
#(
  parameter int MAX_CRC_WIDTH = DEF_MAX_CRC_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_DW-1:0]  in_data_byte,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_DW-1:0] out_crc_value,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int WW  = MAX_CRC_WIDTH;
  localparam int RW  = (WW < 32) ? WW : 32;
  localparam int EW  = $clog2(WW + 1);
  localparam int SHW = $clog2(WW);

  // configuration registers
  logic [WIDTH_FW-1:0] crc_width_r;
  logic [31:0]         poly_r;
  logic [31:0]         init_r;
  logic                refin_r;
  logic                refout_r;
  logic [31:0]         xorout_r;

  logic     cfg_wr;
  reg_idx_t reg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_width_r <= RST_CRC_WIDTH;
      poly_r      <= RST_POLY;
      init_r      <= RST_INIT;
      refin_r     <= 1'b0;
      refout_r    <= 1'b0;
      xorout_r    <= RST_XOROUT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CRC_WIDTH:      crc_width_r <= cfg_pwdata[WIDTH_FW-1:0];
        REG_POLYNOMIAL:     poly_r      <= cfg_pwdata;
        REG_INITIAL_VALUE:  init_r      <= cfg_pwdata;
        REG_REFLECT_INPUT:  refin_r     <= cfg_pwdata[0];
        REG_REFLECT_OUTPUT: refout_r    <= cfg_pwdata[0];
        REG_FINAL_XOR:      xorout_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CRC_WIDTH:      cfg_prdata = CFG_DW'(crc_width_r);
      REG_POLYNOMIAL:     cfg_prdata = poly_r;
      REG_INITIAL_VALUE:  cfg_prdata = init_r;
      REG_REFLECT_INPUT:  cfg_prdata = CFG_DW'(refin_r);
      REG_REFLECT_OUTPUT: cfg_prdata = CFG_DW'(refout_r);
      REG_FINAL_XOR:      cfg_prdata = xorout_r;
      default:            cfg_prdata = '0;
    endcase
  end

  // effective width and alignment shift
  logic [6:0]     wc;
  logic [EW-1:0]  eff_w;
  logic [SHW-1:0] sh;

  always_comb begin
    if (crc_width_r < WIDTH_FW'(MIN_CRC_WIDTH)) begin
      wc = 7'(MIN_CRC_WIDTH);
    end else if ({1'b0, crc_width_r} > 7'(WW)) begin
      wc = 7'(WW);
    end else begin
      wc = {1'b0, crc_width_r};
    end
    eff_w = EW'(wc);
    sh    = SHW'(7'(WW) - wc);
  end

  // handshake and pipeline control
  logic             s1_v_r, s1_v_nxt;
  logic [IN_DW-1:0] s1_byte_r;
  logic             s1_restart_r;
  logic             out_valid_r, out_valid_nxt;
  logic             s2_take, in_acc, s1_adv;

  assign s2_take  = !out_valid_r || out_ready;
  assign in_ready = !s1_v_r || s2_take;
  assign in_acc   = in_valid && in_ready;
  assign s1_adv   = s1_v_r && s2_take;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s2_take) begin
      s1_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r    <= in_data_byte;
      s1_restart_r <= in_restart;
    end
  end

  // crc datapath, division done left-aligned in the top eff_w bits
  logic [RW-1:0]     crc_r, crc_nxt;
  logic [OUT_DW-1:0] out_crc_value_r, out_crc_value_nxt;
  logic [WW-1:0]     reg_al, poly_al, mask_ww, res_ww, rev_al;
  logic [7:0]        byte_in;

  always_comb begin
    byte_in = refin_r ? rev8(s1_byte_r) : s1_byte_r;
    reg_al  = (s1_restart_r ? WW'(init_r) : WW'(crc_r)) << sh;
    poly_al = WW'(poly_r) << sh;
    reg_al[WW-1 -: 8] = reg_al[WW-1 -: 8] ^ byte_in;
    for (int i = 0; i < 8; i++) begin
      if (reg_al[WW-1]) begin
        reg_al = (reg_al << 1) ^ poly_al;
      end else begin
        reg_al = reg_al << 1;
      end
    end
    for (int j = 0; j < WW; j++) begin
      rev_al[j] = reg_al[WW-1-j];
    end
    mask_ww           = {WW{1'b1}} >> sh;
    crc_nxt           = RW'(reg_al >> sh);
    res_ww            = refout_r ? rev_al : (reg_al >> sh);
    res_ww            = res_ww ^ (WW'(xorout_r) & mask_ww);
    out_crc_value_nxt = OUT_DW'(res_ww);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= {RW{1'b1}};
    end else if (s1_adv) begin
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_crc_value_r <= out_crc_value_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_value_r;

`ifndef ASSERT_OFF
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && out_valid_r))
    else $error("input stalled with an empty input register");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced byte produced no result");

  a_high_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_crc_value_r >> eff_w) == '0))
    else $error("crc word has bits above the width");

  a_reset_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (crc_r == {RW{1'b1}}))
    else $error("crc register not all ones after reset");
`endif

endmodule

FILE: dv/crc_engine_checker.sv
// ----------------------------------------------------------------------------
// crc_engine_checker
// watches the crc engine ports, predicts every crc word and compares
// ----------------------------------------------------------------------------
// Follows register writes on the cfg port to keep its own copy of the engine
// settings and crc register. Each accepted input byte produces one expected
// crc word, which is queued and compared in order against the accepted
// result words. Mismatches and unexpected results are reported and counted.
// ----------------------------------------------------------------------------
module crc_engine_checker
  import pce_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_CRC_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [IN_DW-1:0]  in_data_byte,
  input  logic              in_restart,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [OUT_DW-1:0] out_crc_value,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                pending
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [WIDTH_FW-1:0] set_width;
  logic [31:0]         set_poly;
  logic [31:0]         set_init;
  logic                set_refin;
  logic                set_refout;
  logic [31:0]         set_xorout;
  logic [31:0]         crc_state;
  logic [31:0]         crc_expect_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [63:0] mirror_bits(input logic [63:0] v, input int unsigned n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < n; i++) begin
      r[n-1-i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [31:0] advance_crc(input logic [7:0] data, input logic restart);
    int unsigned w;
    logic [63:0] msk;
    logic [63:0] crc_v;
    logic [63:0] poly_v;
    logic [63:0] b;
    logic [63:0] res;
    w = 32'(set_width);
    if (w < MIN_CRC_WIDTH) w = MIN_CRC_WIDTH;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    msk = (64'd1 << w) - 64'd1;
    poly_v = {32'b0, set_poly} & msk;
    if (restart) crc_state = set_init & msk[31:0];
    crc_v = {32'b0, crc_state} & msk;
    b = {56'b0, data};
    if (set_refin) b = mirror_bits(b, 8);
    crc_v = crc_v ^ (b << (w - 8));
    for (int i = 0; i < 8; i++) begin
      if (crc_v[w-1]) crc_v = ((crc_v << 1) ^ poly_v) & msk;
      else crc_v = (crc_v << 1) & msk;
    end
    crc_state = crc_v[31:0];
    res = set_refout ? mirror_bits(crc_v, w) : crc_v;
    res = (res ^ ({32'b0, set_xorout} & msk)) & msk;
    return res[31:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %08h expected %08h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      set_width  = RST_CRC_WIDTH;
      set_poly   = RST_POLY;
      set_init   = RST_INIT;
      set_refin  = 1'b0;
      set_refout = 1'b0;
      set_xorout = RST_XOROUT;
      crc_state  = 32'hFFFF_FFFF;
      crc_expect_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_CRC_WIDTH:      set_width  = cfg_pwdata[WIDTH_FW-1:0];
          REG_POLYNOMIAL:     set_poly   = cfg_pwdata;
          REG_INITIAL_VALUE:  set_init   = cfg_pwdata;
          REG_REFLECT_INPUT:  set_refin  = cfg_pwdata[0];
          REG_REFLECT_OUTPUT: set_refout = cfg_pwdata[0];
          REG_FINAL_XOR:      set_xorout = cfg_pwdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (crc_expect_q.size() == 0) begin
          report_mismatch("unexpected crc word", out_crc_value, 32'h0);
        end else begin
          want = crc_expect_q.pop_front();
          if (out_crc_value !== want) report_mismatch("crc_value", out_crc_value, want);
        end
      end
      if (in_valid && in_ready) begin
        crc_expect_q.push_back(advance_crc(in_data_byte, in_restart));
      end
    end
    pending <= crc_expect_q.size();
  end

endmodule

FILE: dv/tb_parameterized_crc_engine.sv
// ----------------------------------------------------------------------------
// tb_parameterized_crc_engine
// stimulus and verdict for the parameterized crc engine
// ----------------------------------------------------------------------------
// Streams bytes through the engine under a series of register settings:
// first short directed messages around width clamping, reflection and
// restart handling, then random messages under random settings with random
// gaps on the input and random stalls on the result side. The checker
// beside the engine predicts and compares every crc word.
// ----------------------------------------------------------------------------
module tb_parameterized_crc_engine;
  import pce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int         STALL_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [IN_DW-1:0]  in_data_byte = '0;
  logic              in_restart = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [OUT_DW-1:0] out_crc_value;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  logic              quiet = 1'b0;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  parameterized_crc_engine DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_crc_value(out_crc_value),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  crc_engine_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_crc_value(out_crc_value),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_pready   (cfg_pready),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly short pauses, a few long ones
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  initial begin
    int on_len;
    int off_len;
    forever begin
      out_ready <= 1'b1;
      on_len = $urandom_range(1, 12);
      repeat (on_len) @(posedge clk);
      off_len = pick_pause();
      if (off_len > 0) begin
        out_ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic restart);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_restart   <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_random_setup();
    int r;
    logic [31:0] width_v;
    wait_drained();
    r = $urandom_range(0, 9);
    case (r)
      0:       width_v = $urandom_range(0, 7);
      1:       width_v = 32'd8;
      2:       width_v = 32'd32;
      3:       width_v = $urandom_range(33, 63);
      default: width_v = $urandom_range(9, 31);
    endcase
    if ($urandom_range(0, 3) == 0) width_v = width_v | ($urandom() & 32'hFFFF_FFC0);
    cfg_write(REG_CRC_WIDTH, width_v);
    cfg_write(REG_POLYNOMIAL, pick_word());
    cfg_write(REG_INITIAL_VALUE, pick_word());
    cfg_write(REG_REFLECT_INPUT, $urandom());
    cfg_write(REG_REFLECT_OUTPUT, $urandom());
    cfg_write(REG_FINAL_XOR, pick_word());
  endtask

  initial begin
    int phase;
    int sent;
    int msg_len;
    bit first_msg;
    bit paused;
    logic rs;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, register restarted only on the third byte
    quiet <= 1'b1;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    wait_drained();

    // width below minimum, both reflections
    quiet <= 1'b0;
    cfg_write(REG_CRC_WIDTH, 32'd5);
    cfg_write(REG_POLYNOMIAL, 32'h0000_001D);
    cfg_write(REG_INITIAL_VALUE, 32'hFFFF_FFFF);
    cfg_write(REG_REFLECT_INPUT, 32'd1);
    cfg_write(REG_REFLECT_OUTPUT, 32'd1);
    cfg_write(REG_FINAL_XOR, 32'hFFFF_FFFF);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_drained();

    // width above maximum, writes to unmapped addresses
    cfg_write(REG_CRC_WIDTH, 32'd63);
    cfg_write(REG_POLYNOMIAL, 32'h8141_41AB);
    cfg_write(REG_INITIAL_VALUE, 32'h0);
    cfg_write(REG_REFLECT_INPUT, 32'd0);
    cfg_write(REG_FINAL_XOR, 32'h1234_5678);
    cfg_write(REG_SPARE_A, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_B, 32'hDEAD_BEEF);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b0);
    wait_drained();

    // width narrowed in the middle of a message
    cfg_write(REG_CRC_WIDTH, 32'd16);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();

    cfg_write(REG_CRC_WIDTH, 32'd0);
    cfg_write(REG_REFLECT_OUTPUT, 32'd0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);

    paused = 1'b0;
    for (phase = 0; phase < 10; phase++) begin
      quiet <= (phase == 1 || phase == 6);
      program_random_setup();
      first_msg = 1'b1;
      sent = 0;
      while (sent < 40) begin
        if (phase == 3 && sent >= 20 && !paused) begin
          paused = 1'b1;
          wait_drained();
        end
        if ($urandom_range(0, 9) == 0) begin
          send_byte(pick_byte(), 1'($urandom_range(0, 1)));
          sent++;
        end else begin
          msg_len = $urandom_range(1, 12);
          for (int k = 0; k < msg_len; k++) begin
            rs = (k == 0) && !(first_msg && $urandom_range(0, 3) == 0);
            send_byte(pick_byte(), rs);
            sent++;
          end
        end
        first_msg = 1'b0;
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
